// ----- hw/rtl/int_to_radix_ascii_core_macros.svh -----
// assertion macros shared by the int_to_radix_ascii_core checker
`ifndef INT_TO_RADIX_ASCII_CORE_MACROS_SVH
`define INT_TO_RADIX_ASCII_CORE_MACROS_SVH

// same-cycle implication, idle during reset
`define ITRA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define ITRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked while reset is applied
`define ITRA_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/itra_pkg.sv -----
// shared types, constants and helpers for the integer to radix text converter
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned DIGIT_W   = 5;
    localparam int unsigned RADIX_W   = 6;
    localparam int unsigned STEP_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_V     = 7'h56;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] DEC_DIGITS = 7'd10;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // what the emit stage holds
    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_SIGN,
        KIND_ERR
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_en;
        logic issue_err;
        logic issue_sign;
        logic issue_digit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic radix_bad;
        logic div_done;
        logic neg;
        logic emit_ready;
        logic last_digit;
    } status_t;

    // digit value to ascii
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (dx < DEC_DIGITS) begin
            digit_char = CHAR_ZERO + dx;
        end else begin
            digit_char = CHAR_A + dx - DEC_DIGITS;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/int_to_radix_ascii_core.sv -----
// top level of the integer to radix ascii text converter
`timescale 1ns / 1ps
`default_nettype none

// Converts each signed VALUE_WIDTH-bit input word to its text in the radix held
// in the 6-bit radix register (reset 10, valid 2..32), one ASCII character per
// output word, most significant first, with a leading '-' for negative values.
// Digits are 0-9 then A-V; the last character has tlast set. Zero gives "0" and
// the most negative value converts cleanly. A radix outside 2..32 gives one
// word with character 0, tlast and tuser set. One word is converted at a time:
// each digit is extracted in the shared divider (8 quotient bits per cycle), then
// the characters leave one per cycle while the output is taken, through the
// output pipe. The next word is accepted as soon as the last character has
// entered the output pipe.
module int_to_radix_ascii_core
    import itra_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [RADIX_W-1:0]                     cfg_wr_data,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // [VALUE_WIDTH-1:0] number, zero padding above
    input  wire logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // [6:0] character, [7] zero
    output logic [7:0]                                  m_tdata,
    // is_last
    output logic                                        m_tlast,
    // [0] radix_error
    output logic                                        m_tuser
);

    cmd_t              cmd;
    status_t           status;
    logic [CHAR_W-1:0] m_char;

    // control
    itra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    itra_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_number    (s_tdata[VALUE_WIDTH-1:0]),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_char      (m_char),
        .m_last      (m_tlast),
        .m_err       (m_tuser)
    );

    assign m_tdata = {1'b0, m_char};

endmodule

`default_nettype wire

// ----- hw/rtl/itra_ctrl.sv -----
// controller state machine: sequences load, digit extraction and character emission
`timescale 1ns / 1ps
`default_nettype none

module itra_ctrl
    import itra_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.radix_bad ? ST_ERR : ST_DIV;
                end
            end
            ST_ERR: begin
                if (status.emit_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (status.emit_ready) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.emit_ready && status.last_digit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid && !status.radix_bad;
            end
            ST_ERR:  cmd.issue_err   = status.emit_ready;
            ST_DIV:  cmd.div_en      = 1'b1;
            ST_SIGN: cmd.issue_sign  = status.emit_ready;
            ST_EMIT: cmd.issue_digit = status.emit_ready;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/itra_datapath.sv -----
// datapath: radix register, digit-serial divider, digit store and two-stage output pipe
`timescale 1ns / 1ps
`default_nettype none

module itra_datapath
    import itra_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [RADIX_W-1:0]       cfg_wr_data,
    input  wire logic [VALUE_WIDTH-1:0]   s_number,
    input  wire cmd_t                     cmd,
    output status_t                       status,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [CHAR_W-1:0]             m_char,
    output logic                          m_last,
    output logic                          m_err
);

    localparam int unsigned DIV_W  = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int unsigned GROUPS = DIV_W / STEP_BITS;
    localparam int unsigned GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int unsigned AW     = $clog2(VALUE_WIDTH);
    localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(GROUPS - 1);

    logic [RADIX_W-1:0] radix_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [GRP_W-1:0]   grp_reg;
    logic [AW-1:0]      cnt_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic               neg_reg;

    logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

    logic               s1_valid_reg;
    kind_t              s1_kind_reg;
    logic               s1_last_reg;
    logic [DIGIT_W-1:0] s1_digit_reg;

    logic               m_valid_reg;
    logic [CHAR_W-1:0]  m_char_reg;
    logic               m_last_reg;
    logic               m_err_reg;

    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [DIV_W-1:0]       quo_step;
    logic [DIGIT_W-1:0]     rem_step;
    logic                   grp_last;
    logic                   s2_free;
    logic                   emit_ready;
    logic                   issue;
    logic [CHAR_W-1:0]      s1_char;

    // sign and magnitude of the incoming word
    assign in_neg = s_number[VALUE_WIDTH-1];
    assign in_mag = in_neg ? (~s_number + 1'b1) : s_number;

    // one group of restoring division steps per cycle
    always_comb begin
        logic [DIV_W-1:0]   q;
        logic [DIGIT_W-1:0] r;
        logic [RADIX_W-1:0] trial;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {r, q[DIV_W-1]};
            q     = {q[DIV_W-2:0], 1'b0};
            if (trial >= radix_reg) begin
                trial = trial - radix_reg;
                q[0]  = 1'b1;
            end
            r = trial[DIGIT_W-1:0];
        end
        quo_step = q;
        rem_step = r;
    end

    assign grp_last = (grp_reg == GRP_LAST);

    // emit pipe flow
    assign s2_free    = !m_valid_reg || m_tready;
    assign emit_ready = !s1_valid_reg || s2_free;
    assign issue      = cmd.issue_err || cmd.issue_sign || cmd.issue_digit;

    // status to controller
    always_comb begin
        status.radix_bad  = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
        status.div_done   = cmd.div_en && grp_last && (quo_step == '0);
        status.neg        = neg_reg;
        status.emit_ready = emit_ready;
        status.last_digit = (rd_ptr_reg == '0);
    end

    // radix register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= cfg_wr_data;
        end
    end

    // divider and digit counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quo_reg    <= '0;
            rem_reg    <= '0;
            grp_reg    <= '0;
            cnt_reg    <= '0;
            rd_ptr_reg <= '0;
            neg_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                quo_reg <= DIV_W'(in_mag);
                rem_reg <= '0;
                grp_reg <= '0;
                cnt_reg <= '0;
                neg_reg <= in_neg;
            end else if (cmd.div_en) begin
                if (grp_last) begin
                    quo_reg    <= quo_step;
                    rem_reg    <= '0;
                    grp_reg    <= '0;
                    cnt_reg    <= cnt_reg + 1'b1;
                    rd_ptr_reg <= cnt_reg;
                end else begin
                    quo_reg <= quo_step;
                    rem_reg <= rem_step;
                    grp_reg <= grp_reg + 1'b1;
                end
            end
            if (cmd.issue_digit) begin
                rd_ptr_reg <= rd_ptr_reg - 1'b1;
            end
        end
    end

    // digit store, least significant digit first
    always_ff @(posedge aclk) begin
        if (cmd.div_en && grp_last) begin
            digit_mem[cnt_reg] <= rem_step;
        end
        if (cmd.issue_digit) begin
            s1_digit_reg <= digit_mem[rd_ptr_reg];
        end
    end

    // stage one: what is to be sent next
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (issue) begin
            s1_valid_reg <= 1'b1;
        end else if (s2_free) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            priority if (cmd.issue_err) begin
                s1_kind_reg <= KIND_ERR;
                s1_last_reg <= 1'b1;
            end else if (cmd.issue_sign) begin
                s1_kind_reg <= KIND_SIGN;
                s1_last_reg <= 1'b0;
            end else begin
                s1_kind_reg <= KIND_DIGIT;
                s1_last_reg <= (rd_ptr_reg == '0);
            end
        end
    end

    // character for stage one contents
    always_comb begin
        unique case (s1_kind_reg)
            KIND_DIGIT: s1_char = digit_char(s1_digit_reg);
            KIND_SIGN:  s1_char = CHAR_MINUS;
            KIND_ERR:   s1_char = CHAR_NONE;
            default:    s1_char = CHAR_NONE;
        endcase
    end

    // stage two: output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_free && s1_valid_reg) begin
            m_char_reg <= s1_char;
            m_last_reg <= s1_last_reg;
            m_err_reg  <= (s1_kind_reg == KIND_ERR);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_char   = m_char_reg;
    assign m_last   = m_last_reg;
    assign m_err    = m_err_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/itra_checker.sv -----
// port-level checker for int_to_radix_ascii_core and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "int_to_radix_ascii_core_macros.svh"

module itra_checker
    import itra_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    // an error word stands alone and carries no character
    `ITRA_ASSERT_SAME(a_err_single, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'h00), "error word must be a lone last word with character 0")

    // every other word is a sign or a digit of the radix alphabet
    `ITRA_ASSERT_SAME(a_char_legal, m_tvalid && !m_tuser, (m_tdata[6:0] == CHAR_MINUS) || ((m_tdata[6:0] >= CHAR_ZERO) && (m_tdata[6:0] <= CHAR_NINE)) || ((m_tdata[6:0] >= CHAR_A) && (m_tdata[6:0] <= CHAR_V)), "illegal output character")

    // the sign never ends the text
    `ITRA_ASSERT_SAME(a_sign_not_last, m_tvalid && !m_tuser && (m_tdata[6:0] == CHAR_MINUS), !m_tlast, "sign marked as last character")

    // a stalled word holds
    `ITRA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled output word changed")

    // nothing is shown right after reset
    `ITRA_ASSERT_RESET(a_reset_quiet, !aresetn, !m_tvalid, "output valid after reset")

endmodule

bind int_to_radix_ascii_core itra_checker u_itra_checker (.*);

`default_nettype wire
